// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the azimuth filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define LAWF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// checked at every edge, reset included
`define LAWF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define LAWF_ASSERT(lbl, prop, msg)
`define LAWF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/lawf_pkg.sv =====
// ---------------------------------------------------------------------------
// lawf_pkg
// Types, widths and constant tables of the lidar azimuth window filter.
// ---------------------------------------------------------------------------
package lawf_pkg;

  // input field widths
  localparam int COORD_W = 32;
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 32;
  localparam int IN_W    = 176;   // 22 bytes, no padding
  localparam int OUT_W   = 136;   // 133 bits padded to 17 bytes

  // configuration port
  localparam int AZ_W      = 17;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AZ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AZ = 1'b1;
  localparam logic signed [AZ_W-1:0] MIN_AZ_RST = -17'sd30720;
  localparam logic signed [AZ_W-1:0] MAX_AZ_RST = 17'sd30720;

  // CORDIC datapath
  localparam int CX_W = 36;   // x/y with gain and pre-rotation headroom
  localparam int CZ_W = 26;   // angle in 1/65536 degree
  localparam logic signed [CZ_W-1:0] Z_POS90  = 26'sd5898240;
  localparam logic signed [CZ_W-1:0] Z_NEG90  = -26'sd5898240;
  localparam logic signed [CZ_W-1:0] Z_ROUND  = 26'sd128;
  localparam logic signed [CZ_W-1:0] AZ_LIMIT = 26'sd46080;

  // curvature divider: 13 quotient bits, one per cell
  localparam int REM_W = 49;
  localparam int DEN_W = 36;
  localparam int QUO_W = 13;
  localparam logic [QUO_W-1:0] CURV_SAT = 13'd6554;

  // intensity: reflect/10000 by reciprocal, ceil(2^37/10000)
  localparam int FRAC_W   = 11;
  localparam int INT_W    = 24;
  localparam int RECIP_SH = 37;
  localparam logic [23:0] RECIP_10K  = 24'd13743896;
  localparam logic [23:0] INT_ROUND  = 24'd5000;
  localparam logic [FRAC_W-1:0] INT_FRAC_MAX = 11'd1671;

  // data handed from cell to cell
  typedef struct packed {
    logic signed [CX_W-1:0]    cx;
    logic signed [CX_W-1:0]    cy;
    logic signed [CZ_W-1:0]    cz;
    logic                      origin;
    logic [REM_W-1:0]          rem;
    logic [DEN_W-1:0]          den;
    logic [QUO_W-1:0]          quo;
    logic                      sat;
    logic [COORD_W-1:0]        x_mm;
    logic [COORD_W-1:0]        y_mm;
    logic [COORD_W-1:0]        z_mm;
    logic [FRAC_W-1:0]         frac;
    logic [BYTE_W-1:0]         line;
  } lawf_cell_t;

  // atan(2^-i) in 1/65536 degree, rounded
  function automatic logic signed [CZ_W-1:0] atan_q16(input int i);
    logic signed [CZ_W-1:0] v;
    case (i)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/lawf_prep.sv =====
// ---------------------------------------------------------------------------
// lawf_prep
// Entry stage: quadrant pre-rotation, divider setup, intensity fraction.
// ---------------------------------------------------------------------------
module lawf_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [lawf_pkg::IN_W-1:0]     up_data,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output lawf_pkg::lawf_cell_t          dn_data
);
  import lawf_pkg::*;

  logic                      valid_r;
  lawf_cell_t                data_r;
  lawf_cell_t                data_nxt;

  logic signed [COORD_W-1:0] x_s;
  logic signed [COORD_W-1:0] y_s;
  logic signed [CX_W-1:0]    x_e;
  logic signed [CX_W-1:0]    y_e;
  logic [BYTE_W-1:0]         refl;
  logic [TIME_W-1:0]         off;
  logic [TIME_W-1:0]         pend;
  logic [23:0]               int_num;
  logic [47:0]               int_prod;

  // field unpacking
  assign x_s  = $signed(up_data[31:0]);
  assign y_s  = $signed(up_data[63:32]);
  assign refl = up_data[103:96];
  assign off  = up_data[143:112];
  assign pend = up_data[175:144];
  assign x_e  = CX_W'(x_s);
  assign y_e  = CX_W'(y_s);

  // reflect*65536 + 5000, scaled by the reciprocal of 10000
  assign int_num  = {refl, 16'd0} + INT_ROUND;
  assign int_prod = 48'(int_num) * 48'(RECIP_10K);

  always_comb begin
    data_nxt        = '0;
    data_nxt.x_mm   = up_data[31:0];
    data_nxt.y_mm   = up_data[63:32];
    data_nxt.z_mm   = up_data[95:64];
    data_nxt.line   = up_data[111:104];
    data_nxt.frac   = int_prod[RECIP_SH +: FRAC_W];
    data_nxt.origin = (x_s == '0) && (y_s == '0);
    // turn left half plane points into the right half plane
    if (x_s[COORD_W-1] && !y_s[COORD_W-1]) begin
      data_nxt.cx = y_e;
      data_nxt.cy = -x_e;
      data_nxt.cz = Z_POS90;
    end else if (x_s[COORD_W-1]) begin
      data_nxt.cx = -y_e;
      data_nxt.cy = x_e;
      data_nxt.cz = Z_NEG90;
    end else begin
      data_nxt.cx = x_e;
      data_nxt.cy = y_e;
      data_nxt.cz = '0;
    end
    // divider: (off*65536 + 5*end) / (10*end)
    data_nxt.rem = REM_W'({off, 16'd0}) + REM_W'({pend, 2'b00}) + REM_W'(pend);
    data_nxt.den = DEN_W'({pend, 3'b000}) + DEN_W'({pend, 1'b0});
    data_nxt.quo = '0;
    data_nxt.sat = (pend == '0) || (off > pend);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== src/lawf_cell.sv =====
// ---------------------------------------------------------------------------
// lawf_cell
// One chain cell: a CORDIC vectoring step if ROT_EN, one restoring divide step if DIV_EN.
// ---------------------------------------------------------------------------
module lawf_cell #(
  parameter int STAGE     = 0,
  parameter bit ROT_EN    = 1'b1,
  parameter bit DIV_EN    = 1'b1,
  parameter int DIV_SHIFT = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  lawf_pkg::lawf_cell_t  up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output lawf_pkg::lawf_cell_t  dn_data
);
  import lawf_pkg::*;

  logic                   valid_r;
  lawf_cell_t             data_r;
  lawf_cell_t             data_nxt;

  logic signed [CX_W-1:0] cx;
  logic signed [CX_W-1:0] cy;
  logic signed [CX_W-1:0] cx_sh;
  logic signed [CX_W-1:0] cy_sh;
  logic [REM_W-1:0]       den_sh;
  logic                   den_fit;

  assign cx     = up_data.cx;
  assign cy     = up_data.cy;
  assign cx_sh  = cx >>> STAGE;
  assign cy_sh  = cy >>> STAGE;
  assign den_sh = REM_W'(up_data.den) << DIV_SHIFT;
  assign den_fit = (up_data.rem >= den_sh);

  always_comb begin
    data_nxt = up_data;
    // vectoring step: drive y toward zero
    if (ROT_EN) begin
      if (!cy[CX_W-1]) begin
        data_nxt.cx = cx + cy_sh;
        data_nxt.cy = cy - cx_sh;
        data_nxt.cz = up_data.cz + atan_q16(STAGE);
      end else begin
        data_nxt.cx = cx - cy_sh;
        data_nxt.cy = cy + cx_sh;
        data_nxt.cz = up_data.cz - atan_q16(STAGE);
      end
    end
    // one quotient bit, most significant first
    if (DIV_EN && den_fit) begin
      data_nxt.rem = up_data.rem - den_sh;
      data_nxt.quo = up_data.quo | (QUO_W'(1) << DIV_SHIFT);
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== src/lawf_out.sv =====
// ---------------------------------------------------------------------------
// lawf_out
// Final stage: azimuth rounding and clamp, window test, result register.
// ---------------------------------------------------------------------------
module lawf_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [lawf_pkg::AZ_W-1:0] min_az,
  input  logic signed [lawf_pkg::AZ_W-1:0] max_az,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  lawf_pkg::lawf_cell_t          up_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lawf_pkg::OUT_W-1:0]    out_data
);
  import lawf_pkg::*;

  logic                     valid_r;
  logic [COORD_W-1:0]       x_r;
  logic [COORD_W-1:0]       y_r;
  logic [COORD_W-1:0]       z_r;
  logic [INT_W-1:0]         inten_r;
  logic [QUO_W-1:0]         curv_r;

  logic signed [CZ_W-1:0]   z_rnd;
  logic signed [AZ_W-1:0]   az;
  logic                     keep;

  // round half up to 1/256 degree, clamp to +-180 degrees
  assign z_rnd = (up_data.cz + Z_ROUND) >>> 8;

  always_comb begin
    if (up_data.origin) begin
      az = '0;
    end else if (z_rnd > AZ_LIMIT) begin
      az = AZ_W'(AZ_LIMIT);
    end else if (z_rnd < -AZ_LIMIT) begin
      az = AZ_W'(-AZ_LIMIT);
    end else begin
      az = AZ_W'(z_rnd);
    end
  end

  assign keep     = (az >= min_az) && (az <= max_az);
  assign up_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid && keep;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r     <= up_data.x_mm;
      y_r     <= up_data.y_mm;
      z_r     <= up_data.z_mm;
      inten_r <= {up_data.line, (16 - FRAC_W)'(0), up_data.frac};
      curv_r  <= up_data.sat ? CURV_SAT : up_data.quo;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = {3'b000, curv_r, inten_r, z_r, y_r, x_r};

endmodule

// ===== src/lidar_azimuth_window_filter.sv =====
// ---------------------------------------------------------------------------
// lidar_azimuth_window_filter
// Azimuth crop filter for a lidar point stream, CORDIC cell chain.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : one point per request (x, y, z, reflect, line, offset, end).
//   out_*  : one request per kept point (x, y, z, intensity, curvature);
//            points whose azimuth falls outside [min, max] give nothing.
//   cfg_*  : index 0 writes the lower azimuth bound, index 1 the upper
//            bound, 1/256 degree, inclusive; write only while idle.
// Pipeline: the entry stage, the cell chain (at most one CORDIC step and
//   one quotient bit per cell) and the result register, each registered.
// Throughput: one point per cycle while out_tready is high; every stage
//   holds its own valid bit, so empty stages and dropped points leave
//   room for new input.
// Stall: when out_tready is low the chain fills up behind the result
//   register; in_tready falls only once every stage holds a point.
// Reset: all stages empty, bounds return to -120 and +120 degrees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lidar_azimuth_window_filter #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: x_mm, y_mm, z_mm, reflect, laser_line, point_offset_ns,
  //           packet_end_ns (lowest bits first)
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lawf_pkg::IN_W-1:0]     in_tdata,
  // out_tdata: out_x_mm, out_y_mm, out_z_mm, intensity_q16,
  //            curvature_q16, zero fill (lowest bits first)
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lawf_pkg::OUT_W-1:0]    out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [lawf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lawf_pkg::AZ_W-1:0]     cfg_data
);
  import lawf_pkg::*;

  localparam int NCELL = (CORDIC_STAGES > QUO_W) ? CORDIC_STAGES : QUO_W;

  logic signed [AZ_W-1:0] min_az_r;
  logic signed [AZ_W-1:0] max_az_r;

  logic       chain_valid [0:NCELL];
  logic       chain_ready [0:NCELL];
  lawf_cell_t chain_data  [0:NCELL];

  // bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_az_r <= MIN_AZ_RST;
      max_az_r <= MAX_AZ_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_AZ: min_az_r <= $signed(cfg_data);
        CFG_MAX_AZ: max_az_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // entry stage
  lawf_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  // cell chain
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    lawf_cell #(
      .STAGE     (g),
      .ROT_EN    (g < CORDIC_STAGES),
      .DIV_EN    (g < QUO_W),
      .DIV_SHIFT ((g < QUO_W) ? (QUO_W - 1 - g) : 0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_data  (chain_data[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_data  (chain_data[g+1])
    );
  end

  // window test and result register
  lawf_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .min_az    (min_az_r),
    .max_az    (max_az_r),
    .up_valid  (chain_valid[NCELL]),
    .up_ready  (chain_ready[NCELL]),
    .up_data   (chain_data[NCELL]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  // checks
  `LAWF_ASSERT(a_empty_after_reset, $past(!rst_n) |-> !out_tvalid, "result after reset")
  `LAWF_ASSERT(a_stall_from_output, !in_tready |-> (out_tvalid && !out_tready), "input stalled without output stall")
  `LAWF_ASSERT(a_curv_range, out_tvalid |-> (out_tdata[132:120] <= CURV_SAT), "curvature above saturation")
  `LAWF_ASSERT(a_inten_frac, out_tvalid |-> (out_tdata[111:96] <= 16'(INT_FRAC_MAX)), "intensity fraction out of range")

endmodule
